FILE: src/fpx_pkg.sv
`default_nettype none

package fpx_pkg;

  localparam int unsigned MAX_PAYLOAD = 32767;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);

  localparam logic CFG_HEADER_WORD = 1'b0;
  localparam logic CFG_COVERS_HDR = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR1 = 4'd1,
    PH_TYPE = 4'd2,
    PH_CMD  = 4'd3,
    PH_DEV0 = 4'd4,
    PH_DEV1 = 4'd5,
    PH_DEV2 = 4'd6,
    PH_DEV3 = 4'd7,
    PH_LENH = 4'd8,
    PH_LENL = 4'd9,
    PH_PAY  = 4'd10,
    PH_CHK  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_LENGTH = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } fpx_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [7:0]  packet_type;
    logic [7:0]  command_code;
    logic [31:0] device_id;
    logic [14:0] payload_length;
    logic [7:0]  computed_checksum;
    logic        checksum_ok;
    logic [1:0]  error_code;
  } fpx_out_t;

  typedef struct packed {
    logic       we;
    logic       idx;
    logic [15:0] data;
  } fpx_cfg_t;

endpackage

`default_nettype wire

FILE: src/fpx_front.sv
`default_nettype none

module fpx_front import fpx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fpx_cfg_t cfg_i,
  input  wire logic     acc_i,
  input  wire fpx_in_t  in_data_i,
  output logic          res_valid_o,
  output fpx_out_t      res_data_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] dev_q, dev_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] hdr_word_q;
  logic        covers_q;

  logic [7:0]  b;
  logic [15:0] count_inc;
  logic [15:0] len_full;

  assign b         = in_data_i.rx_byte;
  assign count_inc = count_q + 16'd1;
  assign len_full  = {len_q[15:8], b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_word_q <= '0;
      covers_q   <= 1'b1;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_HEADER_WORD) begin
        hdr_word_q <= cfg_i.data;
      end else begin
        covers_q <= cfg_i.data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      type_q  <= '0;
      cmd_q   <= '0;
      dev_q   <= '0;
      len_q   <= '0;
      xor_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      type_q  <= type_d;
      cmd_q   <= cmd_d;
      dev_q   <= dev_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
    end
  end

  // Next-state and field capture for one accepted byte.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    type_d  = type_q;
    cmd_d   = cmd_q;
    dev_d   = dev_q;
    len_d   = len_q;
    xor_d   = xor_q;
    if (in_data_i.frame_start) begin
      count_d = '0;
      type_d  = '0;
      cmd_d   = '0;
      dev_d   = '0;
      len_d   = '0;
      xor_d   = covers_q ? b : 8'h00;
      phase_d = (b == hdr_word_q[15:8]) ? PH_HDR1 : PH_IDLE;
    end else begin
      case (phase_q)
        PH_HDR1: begin
          if (covers_q) begin
            xor_d = xor_q ^ b;
          end
          phase_d = (b == hdr_word_q[7:0]) ? PH_TYPE : PH_IDLE;
        end
        PH_TYPE: begin
          type_d  = b;
          xor_d   = xor_q ^ b;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = b;
          xor_d   = xor_q ^ b;
          phase_d = PH_DEV0;
        end
        PH_DEV0, PH_DEV1, PH_DEV2, PH_DEV3: begin
          dev_d   = {dev_q[23:0], b};
          xor_d   = xor_q ^ b;
          phase_d = (phase_q == PH_DEV3) ? PH_LENH : phase_e'(phase_q + 4'd1);
        end
        PH_LENH: begin
          len_d   = {b, 8'h00};
          xor_d   = xor_q ^ b;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          len_d   = len_full;
          xor_d   = xor_q ^ b;
          count_d = '0;
          if (len_full > MAX_PAYLOAD_W) begin
            phase_d = PH_IDLE;
          end else if (len_full == 16'd0) begin
            phase_d = PH_CHK;
          end else begin
            phase_d = PH_PAY;
          end
        end
        PH_PAY: begin
          xor_d   = xor_q ^ b;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            phase_d = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Result item for the byte offered this cycle; pushed only when accepted.
  always_comb begin
    res_valid_o = 1'b0;
    res_data_o  = '0;
    if (in_data_i.frame_start) begin
      if (b != hdr_word_q[15:8]) begin
        res_valid_o            = acc_i;
        res_data_o.result_kind = KIND_ERROR;
        res_data_o.error_code  = ERR_HEADER;
      end
    end else begin
      case (phase_q)
        PH_HDR1: begin
          if (b != hdr_word_q[7:0]) begin
            res_valid_o            = acc_i;
            res_data_o.result_kind = KIND_ERROR;
            res_data_o.error_code  = ERR_HEADER;
          end
        end
        PH_LENL: begin
          if (len_full > MAX_PAYLOAD_W) begin
            res_valid_o            = acc_i;
            res_data_o.result_kind = KIND_ERROR;
            res_data_o.error_code  = ERR_LENGTH;
          end
        end
        PH_PAY: begin
          res_valid_o             = acc_i;
          res_data_o.result_kind  = KIND_PAYLOAD;
          res_data_o.payload_byte = b;
          res_data_o.last_payload = (count_inc >= len_q);
        end
        PH_CHK: begin
          res_valid_o                  = acc_i;
          res_data_o.result_kind       = KIND_SUMMARY;
          res_data_o.packet_type       = type_q;
          res_data_o.command_code      = cmd_q;
          res_data_o.device_id         = dev_q;
          res_data_o.payload_length    = len_q[14:0];
          res_data_o.computed_checksum = xor_q;
          res_data_o.checksum_ok       = (xor_q == b);
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/fpx_queue.sv
`default_nettype none

module fpx_queue import fpx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire fpx_out_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fpx_out_t      out_data_o
);

  fpx_out_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/framed_packet_parser_xor_check.sv
`default_nettype none

// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+-------------------------
// input    | in        | in_valid_i / in_stall_o     | in_data_i  (fpx_in_t)
// result   | out       | out_valid_o / out_stall_i   | out_data_o (fpx_out_t)
// config   | in        | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One byte is taken every cycle unless input is stalled; the parser decides the
// result of a byte in the cycle it is accepted. Results wait in a four-entry
// queue, so input is stalled only while that queue is full. A result enters the
// queue when its byte is taken. Reset is asynchronous and leaves the parser idle.

module framed_packet_parser_xor_check import fpx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire fpx_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output fpx_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  fpx_cfg_t cfg;
  logic     full;
  logic     acc;
  logic     res_valid;
  fpx_out_t res_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  fpx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .acc_i       (acc),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  fpx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_data),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sim/fpx_result_checker.sv
`default_nettype none

module fpx_result_checker import fpx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire fpx_in_t     in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire fpx_out_t    out_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Shadow copy of the parser configuration and state.
  logic [15:0] hdr_word_q;
  logic        covers_hdr_q;
  phase_e      parse_phase;
  logic [15:0] pay_seen;
  logic [7:0]  type_q;
  logic [7:0]  cmd_q;
  logic [31:0] dev_q;
  logic [15:0] len_q;
  logic [7:0]  xor_acc;

  fpx_out_t results_due[$];
  int       fails;

  function automatic fpx_out_t error_result(err_e code);
    fpx_out_t res;
    res = '0;
    res.result_kind = KIND_ERROR;
    res.error_code = code;
    return res;
  endfunction

  function automatic string field_diffs(fpx_out_t e, fpx_out_t g);
    string s;
    s = "";
    if (e.result_kind !== g.result_kind)
      s = {s, $sformatf(" kind exp %0d got %0d", e.result_kind, g.result_kind)};
    if (e.payload_byte !== g.payload_byte)
      s = {s, $sformatf(" byte exp %h got %h", e.payload_byte, g.payload_byte)};
    if (e.last_payload !== g.last_payload)
      s = {s, $sformatf(" last exp %b got %b", e.last_payload, g.last_payload)};
    if (e.packet_type !== g.packet_type)
      s = {s, $sformatf(" type exp %h got %h", e.packet_type, g.packet_type)};
    if (e.command_code !== g.command_code)
      s = {s, $sformatf(" cmd exp %h got %h", e.command_code, g.command_code)};
    if (e.device_id !== g.device_id)
      s = {s, $sformatf(" dev exp %h got %h", e.device_id, g.device_id)};
    if (e.payload_length !== g.payload_length)
      s = {s, $sformatf(" len exp %0d got %0d", e.payload_length, g.payload_length)};
    if (e.computed_checksum !== g.computed_checksum)
      s = {s, $sformatf(" xor exp %h got %h", e.computed_checksum, g.computed_checksum)};
    if (e.checksum_ok !== g.checksum_ok)
      s = {s, $sformatf(" ok exp %b got %b", e.checksum_ok, g.checksum_ok)};
    if (e.error_code !== g.error_code)
      s = {s, $sformatf(" err exp %0d got %0d", e.error_code, g.error_code)};
    return s;
  endfunction

  // Advances the shadow parser by one accepted byte and queues the result it causes.
  task automatic parse_byte(input fpx_in_t item);
    fpx_out_t   res;
    logic       hit;
    logic [7:0] b;
    res = '0;
    hit = 1'b0;
    b = item.rx_byte;
    if (item.frame_start) begin
      pay_seen = '0;
      type_q = '0;
      cmd_q = '0;
      dev_q = '0;
      len_q = '0;
      xor_acc = covers_hdr_q ? b : 8'h00;
      if (b != hdr_word_q[15:8]) begin
        hit = 1'b1;
        res = error_result(ERR_HEADER);
        parse_phase = PH_IDLE;
      end else begin
        parse_phase = PH_HDR1;
      end
    end else begin
      case (parse_phase)
        PH_HDR1: begin
          if (covers_hdr_q) xor_acc ^= b;
          if (b != hdr_word_q[7:0]) begin
            hit = 1'b1;
            res = error_result(ERR_HEADER);
            parse_phase = PH_IDLE;
          end else begin
            parse_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_q = b;
          xor_acc ^= b;
          parse_phase = PH_CMD;
        end
        PH_CMD: begin
          cmd_q = b;
          xor_acc ^= b;
          parse_phase = PH_DEV0;
        end
        PH_DEV0, PH_DEV1, PH_DEV2, PH_DEV3: begin
          dev_q = {dev_q[23:0], b};
          xor_acc ^= b;
          parse_phase = (parse_phase == PH_DEV3) ? PH_LENH : phase_e'(parse_phase + 4'd1);
        end
        PH_LENH: begin
          len_q = {b, 8'h00};
          xor_acc ^= b;
          parse_phase = PH_LENL;
        end
        PH_LENL: begin
          len_q = {len_q[15:8], b};
          xor_acc ^= b;
          if (len_q > MAX_PAYLOAD_W) begin
            hit = 1'b1;
            res = error_result(ERR_LENGTH);
            parse_phase = PH_IDLE;
          end else begin
            pay_seen = '0;
            parse_phase = (len_q == 16'd0) ? PH_CHK : PH_PAY;
          end
        end
        PH_PAY: begin
          xor_acc ^= b;
          pay_seen = pay_seen + 16'd1;
          hit = 1'b1;
          res.result_kind = KIND_PAYLOAD;
          res.payload_byte = b;
          if (pay_seen >= len_q) begin
            res.last_payload = 1'b1;
            parse_phase = PH_CHK;
          end
        end
        PH_CHK: begin
          hit = 1'b1;
          res.result_kind = KIND_SUMMARY;
          res.packet_type = type_q;
          res.command_code = cmd_q;
          res.device_id = dev_q;
          res.payload_length = len_q[14:0];
          res.computed_checksum = xor_acc;
          res.checksum_ok = (xor_acc == b);
          parse_phase = PH_IDLE;
        end
        default: parse_phase = PH_IDLE;
      endcase
    end
    if (hit) results_due = {results_due, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fpx_out_t want;
    string    diffs;
    if (!rst_ni) begin
      hdr_word_q = 16'h0000;
      covers_hdr_q = 1'b1;
      parse_phase = PH_IDLE;
      pay_seen = '0;
      type_q = '0;
      cmd_q = '0;
      dev_q = '0;
      len_q = '0;
      xor_acc = '0;
      results_due.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          if (fails < 10) $display("%0t: result with nothing expected: kind %0d",
                                   $realtime, out_data_i.result_kind);
          fails++;
        end else begin
          want = results_due.pop_front();
          diffs = field_diffs(want, out_data_i);
          if (diffs != "") begin
            if (fails < 10) $display("%0t: result mismatch:%s", $realtime, diffs);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      // A register write takes effect for bytes accepted after this edge.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEADER_WORD) hdr_word_q = cfg_data_i;
        else covers_hdr_q = cfg_data_i[0];
      end
      pending_o <= results_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

`default_nettype wire

FILE: sim/framed_packet_parser_xor_check_tb.sv
`default_nettype none

module framed_packet_parser_xor_check_tb import fpx_pkg::*; ();

  localparam int NO_CUT = 1 << 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  fpx_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  fpx_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_HEADER_WORD;
  logic [15:0] cfg_data_i = '0;

  int          fail_count;
  int          results_pending;

  // Mirror of the configuration, needed to build frames with a correct checksum.
  logic [15:0] header_word = 16'h0000;
  logic        covers_header = 1'b1;
  bit          steady;
  int          frame_items;

  framed_packet_parser_xor_check DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  fpx_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_backpressure
    int hold;
    forever begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12)) @(negedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{rx_byte: b, frame_start: start};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int pay_len, input bit bad_sum, input int bad_hdr,
                            input int cut_len);
    logic [7:0]  pkt[$];
    logic [7:0]  sum;
    logic [31:0] dev;
    logic [15:0] len_field;
    dev = $urandom();
    len_field = 16'(pay_len);
    pkt = {pkt, header_word[15:8] ^ ((bad_hdr == 1) ? 8'($urandom_range(1, 255)) : 8'h00)};
    pkt = {pkt, header_word[7:0] ^ ((bad_hdr == 2) ? 8'($urandom_range(1, 255)) : 8'h00)};
    pkt = {pkt, 8'($urandom_range(0, 255))};
    pkt = {pkt, 8'($urandom_range(0, 255))};
    for (int i = 3; i >= 0; i--) pkt = {pkt, dev[8*i +: 8]};
    pkt = {pkt, len_field[15:8]};
    pkt = {pkt, len_field[7:0]};
    if (pay_len <= int'(MAX_PAYLOAD)) begin
      for (int i = 0; i < pay_len && pkt.size() < cut_len; i++)
        pkt = {pkt, 8'($urandom_range(0, 255))};
      sum = 8'h00;
      for (int i = covers_header ? 0 : 2; i < pkt.size(); i++) sum ^= pkt[i];
      pkt = {pkt, sum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00)};
    end
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt.size() && i < cut_len; i++) begin
      send_byte(pkt[i], i == 0);
      frame_items++;
    end
  endtask

  task automatic random_packet();
    int r;
    int len;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    if (r < 55) begin
      send_frame(len, $urandom_range(0, 4) == 0, 0, NO_CUT);
    end else if (r < 62) begin
      send_frame(0, 1'($urandom_range(0, 1)), 0, NO_CUT);
    end else if (r < 70) begin
      // Cut short; the next frame start abandons it.
      send_frame(len, 1'b0, 0, $urandom_range(1, len + 10));
    end else if (r < 77) begin
      send_frame(len, 1'b0, $urandom_range(1, 2), NO_CUT);
    end else if (r < 84) begin
      case ($urandom_range(0, 2))
        0: send_frame(int'(MAX_PAYLOAD) + 1, 1'b0, 0, NO_CUT);
        1: send_frame(65535, 1'b0, 0, NO_CUT);
        default: send_frame($urandom_range(int'(MAX_PAYLOAD) + 1, 65535), 1'b0, 0, NO_CUT);
      endcase
    end else if (r < 89) begin
      // Largest legal length is accepted; at most ten payload bytes are sent.
      send_frame(int'(MAX_PAYLOAD), 1'b0, 0, $urandom_range(10, 20));
    end else begin
      steady = 1'b0;
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come out and the parser has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  zero_len_pkt[11];
    logic [7:0]  oversize_pkt[10];
    logic [15:0] hdr_plan[5];
    logic        covers_plan[5];
    zero_len_pkt = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'hFF};
    oversize_pkt = '{8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'hFF, 8'hFF};
    hdr_plan = '{16'h0000, 16'hFFFF, 16'h8001, 16'($urandom()), 16'h7E81};
    covers_plan = '{1'b1, 1'b0, 1'b1, 1'($urandom()), 1'b0};
    frame_items = 0;
    steady = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, run on the reset configuration.
    send_byte(8'hFF, 1'b0);
    foreach (zero_len_pkt[i]) send_byte(zero_len_pkt[i], i == 0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    foreach (oversize_pkt[i]) send_byte(oversize_pkt[i], i == 0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        header_word = hdr_plan[ph];
        covers_header = covers_plan[ph];
        cfg_write(CFG_HEADER_WORD, header_word);
        cfg_write(CFG_COVERS_HDR, 16'(covers_header));
      end
      while (frame_items < (ph + 1) * 100) random_packet();
      send_frame($urandom_range(1, 8), 1'b0, 0, NO_CUT);
    end

    drain();
    if (fail_count == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
